@@ rtl/svfdt_pkg.sv @@
// svfdt_pkg: shared constants, codes and command types for the tom voice core
// used by the channel interfaces, the controller, the datapath and the top level
// no dependencies
`default_nettype none

package svfdt_pkg;

  // field widths
  localparam int COEFF_W   = 25;
  localparam int VEL_W     = 25;
  localparam int SAMPLE_W  = 16;
  localparam int STATE_W   = 32;
  localparam int PROD_W    = 2 * STATE_W;
  localparam int CFG_IDX_W = 2;

  // fixed-point format
  localparam int FRAC_BITS_DEF = 24;
  localparam int OUT_BITS      = 14;
  localparam int IMP_SHIFT     = 2;   // impulse gain of four

  // input function codes
  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_TRIG = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FREQ  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DAMP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY = 2'd2;

  // register reset values
  localparam logic [COEFF_W-1:0] FREQ_RST  = 25'd382400;
  localparam logic [COEFF_W-1:0] DAMP_RST  = 25'd2621440;
  localparam logic [COEFF_W-1:0] DECAY_RST = 25'd16748000;

  // operand pairs of the shared multiplier
  typedef enum logic [2:0] {
    MUL_FREQ_BAND = 3'd0,
    MUL_DAMP_BAND = 3'd1,
    MUL_FREQ_HIGH = 3'd2,
    MUL_BAND_ENV  = 3'd3,
    MUL_ENV_DECAY = 3'd4
  } mul_sel_t;

  // controller to datapath commands
  typedef struct packed {
    logic     accept_trig;
    logic     accept_tick;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     low_upd;
    logic     high_upd;
    logic     band_upd;
    logic     samp_upd;
    logic     env_upd;
    logic     out_load;
  } cmd_t;

endpackage

`default_nettype wire

@@ rtl/svfdt_in_if.sv @@
// svfdt_in_if: input channel of the tom voice core (func and velocity word)
// depends on svfdt_pkg
`default_nettype none

interface svfdt_in_if;
  logic                         valid;
  logic                         ready;
  logic                         func;
  logic [svfdt_pkg::VEL_W-1:0]  velocity;

  modport source (output valid, func, velocity, input ready);
  modport sink   (input valid, func, velocity, output ready);
endinterface

`default_nettype wire

@@ rtl/svfdt_out_if.sv @@
// svfdt_out_if: result channel of the tom voice core (one signed sample word)
// depends on svfdt_pkg
`default_nettype none

interface svfdt_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [svfdt_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, sample, input ready);
  modport sink   (input valid, sample, output ready);
endinterface

`default_nettype wire

@@ rtl/svf_drum_tom_voice_core.sv @@
// Tom drum voice: state-variable filter struck by an impulse, band output
// scaled by a decaying envelope.
//
// Channels: item (sink) takes func and velocity words; func = trigger arms
// the impulse and restarts the envelope at 1.0 and gives no result; func =
// tick advances the filter one sample and yields one word on result
// (source), the signed 16-bit sample. The user is to load coefficients through
// cfg_we / cfg_index / cfg_data only while idle; the block does not enforce it.
// Timing: a trigger is taken in idle and stays there. A tick steps through
// low, high, mfh, band, mbe, samp and env, where its sample is loaded into
// the output register (or later in hold while it is full); the sample is on
// result.valid the cycle after. The next item is taken right after that
// load. A tick runs five multiplies sharing one 32x32 multiplier, each
// product registered before use, plus the high-pass and band update steps.
// Stall: the output register holds a word until taken; a tick that finishes
// while it is still full waits in the controller and item stays not ready.
// Triggers are accepted while a word waits.
// Reset: synchronous rst clears filter state, envelope and impulse to zero,
// loads default coefficients and empties the output register.
`default_nettype none

module svf_drum_tom_voice_core #(
  parameter int FRAC_BITS = svfdt_pkg::FRAC_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [svfdt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [svfdt_pkg::COEFF_W-1:0]   cfg_data,
  svfdt_in_if.sink                             item,
  svfdt_out_if.source                          result
);
  import svfdt_pkg::*;

  cmd_t cmd;
  logic out_free;

  // sequencer
  svfdt_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_func  (item.func),
    .item_ready (item.ready),
    .out_free   (out_free),
    .cmd        (cmd)
  );

  // arithmetic and state
  svfdt_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .velocity  (item.velocity),
    .cmd       (cmd),
    .out_free  (out_free),
    .result    (result)
  );

endmodule

`default_nettype wire

@@ rtl/svfdt_ctrl.sv @@
// svfdt_ctrl: sequencer of the tom voice core, steps the shared multiplier
// and the integrator updates of one tick; depends on svfdt_pkg
`default_nettype none

module svfdt_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            item_valid,
  input  wire logic            item_func,
  output logic                 item_ready,
  input  wire logic            out_free,
  output svfdt_pkg::cmd_t      cmd
);
  import svfdt_pkg::*;

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_LOW  = 9'b000000010,
    ST_HIGH = 9'b000000100,
    ST_MFH  = 9'b000001000,
    ST_BAND = 9'b000010000,
    ST_MBE  = 9'b000100000,
    ST_SAMP = 9'b001000000,
    ST_ENV  = 9'b010000000,
    ST_HOLD = 9'b100000000
  } state_t;

  state_t st, st_next;

  assign item_ready = (st == ST_IDLE);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_IDLE;
    end else begin
      st <= st_next;
    end
  end

  // step decode
  always_comb begin
    cmd     = '0;
    st_next = st;
    unique case (st)
      ST_IDLE: begin
        if (item_valid) begin
          if (item_func == FUNC_TRIG) begin
            cmd.accept_trig = 1'b1;
          end else begin
            cmd.accept_tick = 1'b1;
            cmd.mul_en      = 1'b1;
            cmd.mul_sel     = MUL_FREQ_BAND;
            st_next         = ST_LOW;
          end
        end
      end
      ST_LOW: begin
        cmd.low_upd = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_DAMP_BAND;
        st_next     = ST_HIGH;
      end
      ST_HIGH: begin
        cmd.high_upd = 1'b1;
        st_next      = ST_MFH;
      end
      ST_MFH: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_FREQ_HIGH;
        st_next     = ST_BAND;
      end
      ST_BAND: begin
        cmd.band_upd = 1'b1;
        st_next      = ST_MBE;
      end
      ST_MBE: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_BAND_ENV;
        st_next     = ST_SAMP;
      end
      ST_SAMP: begin
        cmd.samp_upd = 1'b1;
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = MUL_ENV_DECAY;
        st_next      = ST_ENV;
      end
      ST_ENV: begin
        cmd.env_upd = 1'b1;
        if (out_free) begin
          cmd.out_load = 1'b1;
          st_next      = ST_IDLE;
        end else begin
          st_next = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          st_next      = ST_IDLE;
        end
      end
      default: begin
        st_next = ST_IDLE;
      end
    endcase
  end

  // a tick blocks the input until its sample is handed over
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready && item_func == FUNC_TICK) |=> !item_ready)
    else $error("input still open after tick accepted");

  // a trigger leaves the input open
  a_trig_open: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready && item_func == FUNC_TRIG) |=> item_ready)
    else $error("input closed after trigger");

  // waiting for the output slot only follows the envelope step
  a_hold_entry: assert property (@(posedge clk) disable iff (rst)
    (st == ST_HOLD) |-> ($past(st == ST_ENV) || $past(st == ST_HOLD)))
    else $error("hold state entered out of sequence");

endmodule

`default_nettype wire

@@ rtl/svfdt_dp.sv @@
// svfdt_dp: datapath of the tom voice core: coefficient registers, filter and
// envelope state, one shared 32x32 multiplier and the output register
// depends on svfdt_pkg and svfdt_out_if
`default_nettype none

module svfdt_dp #(
  parameter int FRAC_BITS = svfdt_pkg::FRAC_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [svfdt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [svfdt_pkg::COEFF_W-1:0]   cfg_data,
  input  wire logic [svfdt_pkg::VEL_W-1:0]     velocity,
  input  wire svfdt_pkg::cmd_t                 cmd,
  output logic                                 out_free,
  svfdt_out_if.source                          result
);
  import svfdt_pkg::*;

  localparam int IMP_W = FRAC_BITS + IMP_SHIFT + 1;
  localparam logic [STATE_W-1:0] ONE_U = STATE_W'(1) << FRAC_BITS;
  localparam logic signed [STATE_W-1:0] SAT_HI = 32'sd32767;
  localparam logic signed [STATE_W-1:0] SAT_LO = -32'sd32768;

  logic [COEFF_W-1:0]        freq, damp, decay;
  logic signed [STATE_W-1:0] low, band, high, env;
  logic [IMP_W-1:0]          pending, x_imp;
  logic signed [STATE_W-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0]  prod, prod_next;
  logic signed [STATE_W-1:0] q;
  logic signed [STATE_W-1:0] scaled;
  logic [STATE_W-1:0]        vel_ext, vel_clamp;
  logic signed [SAMPLE_W-1:0] sample_hold;
  logic                      res_valid;
  logic signed [SAMPLE_W-1:0] res_sample;

  // coefficient registers
  always_ff @(posedge clk) begin
    if (rst) begin
      freq  <= FREQ_RST;
      damp  <= DAMP_RST;
      decay <= DECAY_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FREQ:  freq  <= cfg_data;
        CFG_DAMP:  damp  <= cfg_data;
        CFG_DECAY: decay <= cfg_data;
        default: ;
      endcase
    end
  end

  // multiplier operand select
  always_comb begin
    mul_a = band;
    mul_b = signed'(STATE_W'(freq));
    unique case (cmd.mul_sel)
      MUL_FREQ_BAND: begin
        mul_a = band;
        mul_b = signed'(STATE_W'(freq));
      end
      MUL_DAMP_BAND: begin
        mul_a = band;
        mul_b = signed'(STATE_W'(damp));
      end
      MUL_FREQ_HIGH: begin
        mul_a = high;
        mul_b = signed'(STATE_W'(freq));
      end
      MUL_BAND_ENV: begin
        mul_a = band;
        mul_b = env;
      end
      MUL_ENV_DECAY: begin
        mul_a = env;
        mul_b = signed'(STATE_W'(decay));
      end
      default: begin
        mul_a = band;
        mul_b = signed'(STATE_W'(freq));
      end
    endcase
  end

  assign prod_next = mul_a * mul_b;

  // registered product, truncated back to the q format with 32-bit wrap
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= prod_next;
    end
  end

  assign q = prod[FRAC_BITS +: STATE_W];

  // velocity clamp to 1.0
  assign vel_ext   = STATE_W'(velocity);
  assign vel_clamp = (vel_ext > ONE_U) ? ONE_U : vel_ext;

  // filter and envelope state
  always_ff @(posedge clk) begin
    if (rst) begin
      low     <= '0;
      band    <= '0;
      env     <= '0;
      pending <= '0;
    end else begin
      if (cmd.accept_trig) begin
        pending <= IMP_W'(vel_clamp << IMP_SHIFT);
        env     <= signed'(ONE_U);
      end
      if (cmd.accept_tick) begin
        pending <= '0;
      end
      if (cmd.low_upd) begin
        low <= low + q;
      end
      if (cmd.band_upd) begin
        band <= band + q;
      end
      if (cmd.env_upd) begin
        env <= q;
      end
    end
  end

  // per-tick scratch: latched impulse and high-pass value
  always_ff @(posedge clk) begin
    if (cmd.accept_tick) begin
      x_imp <= pending;
    end
    if (cmd.high_upd) begin
      high <= signed'(STATE_W'(x_imp)) - low - q;
    end
  end

  // output scaling and saturation
  assign scaled = q >>> (FRAC_BITS - OUT_BITS);

  always_ff @(posedge clk) begin
    if (cmd.samp_upd) begin
      if (scaled > SAT_HI) begin
        sample_hold <= SAT_HI[SAMPLE_W-1:0];
      end else if (scaled < SAT_LO) begin
        sample_hold <= SAT_LO[SAMPLE_W-1:0];
      end else begin
        sample_hold <= scaled[SAMPLE_W-1:0];
      end
    end
  end

  // output register
  assign out_free = !res_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.out_load) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res_sample <= sample_hold;
    end
  end

  assign result.valid  = res_valid;
  assign result.sample = res_sample;

  // a finished sample never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!res_valid || result.ready))
    else $error("output word overwritten");

  // the impulse is consumed by a tick
  a_imp_cleared: assert property (@(posedge clk) disable iff (rst)
    cmd.accept_tick |=> (pending == '0))
    else $error("impulse not cleared by tick");

  // a trigger restarts the envelope at 1.0
  a_env_restart: assert property (@(posedge clk) disable iff (rst)
    cmd.accept_trig |=> (env == signed'(ONE_U)))
    else $error("envelope not restarted by trigger");

endmodule

`default_nettype wire

@@ tb/svf_drum_tom_voice_checker.sv @@
`timescale 1ns / 100ps
// svf_drum_tom_voice_checker: watches the item, result and register ports of the tom voice
// core, predicts every sample word and compares it with the one the core hands out
// depends on svfdt_pkg, svfdt_in_if and svfdt_out_if

module svf_drum_tom_voice_checker #(
  parameter int FRAC_BITS = svfdt_pkg::FRAC_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [svfdt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [svfdt_pkg::COEFF_W-1:0]   cfg_data,
  svfdt_in_if                                  item,
  svfdt_out_if                                 result,
  output int                                   errors,
  output int                                   waiting
);
  import svfdt_pkg::*;

  typedef logic signed [STATE_W-1:0] word_t;

  localparam word_t UNITY      = word_t'(1) <<< FRAC_BITS;
  localparam int    SAMPLE_MAX = 32767;
  localparam int    SAMPLE_MIN = -32768;

  // coefficients as the core should hold them
  logic [COEFF_W-1:0] freq;
  logic [COEFF_W-1:0] damp;
  logic [COEFF_W-1:0] decay;

  // filter and envelope state
  word_t low_acc;
  word_t band_acc;
  word_t env_level;
  word_t impulse;

  logic signed [SAMPLE_W-1:0] sample_q[$];
  int fail_count = 0;
  int due_count = 0;

  assign errors  = fail_count;
  assign waiting = due_count;

  // full signed product, arithmetic shift down, wrap to the state width
  function automatic word_t frac_mul(input word_t a, input word_t b);
    logic signed [PROD_W-1:0] p;
    p = a * b;
    p = p >>> FRAC_BITS;
    return p[STATE_W-1:0];
  endfunction

  // hit: clamp velocity to 1.0, arm an impulse of four times it, restart the envelope
  function automatic void voice_strike(input logic [COEFF_W-1:0] vel);
    word_t level;
    level = (word_t'(vel) > UNITY) ? UNITY : word_t'(vel);
    impulse   = level <<< IMP_SHIFT;
    env_level = UNITY;
  endfunction

  // one sample tick of the filter, returns the saturated output sample
  function automatic logic signed [SAMPLE_W-1:0] voice_tick();
    word_t drive;
    word_t high_pass;
    word_t shaped;
    word_t scaled;
    drive   = impulse;
    impulse = '0;
    low_acc   = low_acc + frac_mul(word_t'(freq), band_acc);
    high_pass = drive - low_acc - frac_mul(word_t'(damp), band_acc);
    band_acc  = band_acc + frac_mul(word_t'(freq), high_pass);
    shaped    = frac_mul(band_acc, env_level);
    env_level = frac_mul(env_level, word_t'(decay));
    scaled    = shaped >>> (FRAC_BITS - OUT_BITS);
    if (scaled > SAMPLE_MAX) return SAMPLE_W'(SAMPLE_MAX);
    if (scaled < SAMPLE_MIN) return SAMPLE_W'(SAMPLE_MIN);
    return scaled[SAMPLE_W-1:0];
  endfunction

  always @(posedge clk) begin
    logic signed [SAMPLE_W-1:0] due;
    if (rst) begin
      freq      = FREQ_RST;
      damp      = DAMP_RST;
      decay     = DECAY_RST;
      low_acc   = '0;
      band_acc  = '0;
      env_level = '0;
      impulse   = '0;
      sample_q.delete();
    end else begin
      // compare an outgoing word with the oldest prediction
      if (result.valid && result.ready) begin
        if (sample_q.size() == 0) begin
          fail_count <= fail_count + 1;
          $error("sample word %0d arrived with nothing expected", result.sample);
        end else begin
          due = sample_q.pop_front();
          if (due !== result.sample) begin
            fail_count <= fail_count + 1;
            $error("sample mismatch: expected %0d, actual %0d", due, result.sample);
          end
        end
      end
      // predict from an incoming word
      if (item.valid && item.ready) begin
        if (item.func == FUNC_TRIG) begin
          voice_strike(item.velocity);
        end else begin
          sample_q.push_back(voice_tick());
        end
      end
      // track register writes, unknown indexes are dropped
      if (cfg_we) begin
        case (cfg_index)
          CFG_FREQ:  freq  = cfg_data;
          CFG_DAMP:  damp  = cfg_data;
          CFG_DECAY: decay = cfg_data;
          default: ;
        endcase
      end
    end
    due_count <= sample_q.size();
  end

endmodule

@@ tb/svf_drum_tom_voice_core_tb.sv @@
`timescale 1ns / 100ps
// svf_drum_tom_voice_core_tb: drives hits, ticks and coefficient writes into the tom voice core
// and gives the verdict; depends on svfdt_pkg, the channel interfaces, the core and the checker

module svf_drum_tom_voice_core_tb;
  import svfdt_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam logic [COEFF_W-1:0]   COEFF_ONE = 25'h1000000;
  localparam logic [COEFF_W-1:0]   COEFF_ALL = 25'h1FFFFFF;
  localparam int PHASES       = 9;
  localparam int PHASE_WORDS  = 60;
  localparam int DRAIN_CYCLES = 16;
  localparam int STALL_LIMIT  = 1000;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COEFF_W-1:0]   cfg_data;
  int                   check_errors;
  int                   check_waiting;
  bit                   no_idle = 1'b0;
  int                   quiet_cycles = 0;

  svfdt_in_if  item();
  svfdt_out_if result();

  svf_drum_tom_voice_core u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item),
    .result    (result)
  );

  svf_drum_tom_voice_checker u_check (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item),
    .result    (result),
    .errors    (check_errors),
    .waiting   (check_waiting)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // idle cycles before a word, none during busy stretches
  function automatic int idle_draw();
    if (no_idle) return 0;
    return $urandom_range(0, 10);
  endfunction

  // offer one word and hold it until taken, returns at the falling edge after
  task automatic send_word(input logic func, input logic [COEFF_W-1:0] vel);
    int gap;
    gap = idle_draw();
    if (gap > 0) begin
      item.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item.valid    <= 1'b1;
    item.func     <= func;
    item.velocity <= vel;
    @(posedge clk);
    while (!item.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // one register write, enable dropped on the next falling edge
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [COEFF_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  // stop sending, let every predicted sample come out, then let the core go quiet
  task automatic settle();
    item.valid <= 1'b0;
    while (check_waiting != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // result side: random stall before each word
  initial begin
    int stall;
    result.ready = 1'b0;
    @(negedge clk);
    forever begin
      stall = idle_draw();
      if (stall > 0) begin
        result.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      result.ready <= 1'b1;
      @(posedge clk);
      while (!result.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (rst || (item.valid && item.ready) || (result.valid && result.ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [COEFF_W-1:0] vel;
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = CFG_FREQ;
    cfg_data      = '0;
    item.valid    = 1'b0;
    item.func     = FUNC_TICK;
    item.velocity = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // full-strength hit on the default coefficients, let it ring
    send_word(FUNC_TRIG, COEFF_ONE);
    repeat (5) send_word(FUNC_TICK, 25'($urandom));
    // velocity with every bit set is clamped to 1.0
    send_word(FUNC_TRIG, COEFF_ALL);
    send_word(FUNC_TICK, 25'($urandom));
    // silent hit
    send_word(FUNC_TRIG, '0);
    send_word(FUNC_TICK, COEFF_ALL);
    // second hit before any tick replaces the first impulse
    send_word(FUNC_TRIG, 25'h0800000);
    send_word(FUNC_TRIG, COEFF_ONE - 25'd1);
    send_word(FUNC_TICK, '0);
    send_word(FUNC_TICK, 25'($urandom));
    // just above 1.0
    send_word(FUNC_TRIG, COEFF_ONE + 25'd1);
    send_word(FUNC_TICK, 25'($urandom));

    // coefficient phases, each followed by random hits and ticks
    for (int p = 0; p < PHASES; p++) begin
      settle();
      case (p)
        0: begin
          cfg_write(CFG_FREQ, FREQ_RST);
          cfg_write(CFG_DAMP, DAMP_RST);
          cfg_write(CFG_DECAY, DECAY_RST);
        end
        1: begin
          cfg_write(CFG_FREQ, '0);
          cfg_write(CFG_DAMP, '0);
          cfg_write(CFG_DECAY, '0);
        end
        // everything at the top, envelope grows and wraps
        2: begin
          cfg_write(CFG_FREQ, COEFF_ALL);
          cfg_write(CFG_DAMP, COEFF_ALL);
          cfg_write(CFG_DECAY, COEFF_ALL);
        end
        // undamped and no decay, integrators run until they wrap
        3: begin
          cfg_write(CFG_FREQ, COEFF_ONE);
          cfg_write(CFG_DAMP, '0);
          cfg_write(CFG_DECAY, COEFF_ONE);
        end
        // a write to the unused index must change nothing
        4: begin
          cfg_write(CFG_SPARE, 25'($urandom));
          cfg_write(CFG_FREQ, 25'($urandom_range(0, 25'h0200000)));
          cfg_write(CFG_DAMP, 25'($urandom_range(0, COEFF_ONE)));
          cfg_write(CFG_DECAY, 25'($urandom_range(25'h0F00000, COEFF_ONE)));
        end
        default: begin
          cfg_write(CFG_FREQ, 25'($urandom_range(0, COEFF_ONE)));
          cfg_write(CFG_DAMP, 25'($urandom_range(0, COEFF_ALL)));
          cfg_write(CFG_DECAY, 25'($urandom_range(25'h0E00000, COEFF_ONE)));
        end
      endcase
      no_idle = (p % 3 == 2);
      repeat (PHASE_WORDS) begin
        if ($urandom_range(0, 99) < 12) begin
          case ($urandom_range(0, 3))
            0:       vel = 25'($urandom);
            1:       vel = COEFF_ONE;
            default: vel = 25'($urandom_range(0, COEFF_ONE));
          endcase
          send_word(FUNC_TRIG, vel);
        end else begin
          send_word(FUNC_TICK, 25'($urandom));
        end
      end
    end

    no_idle = 1'b0;
    settle();
    if (check_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
